[rtl/core/sfc_pkg.sv]
// Shared types, codes and constants for the spectral index surface classifier.
// Used by every module under rtl/core; depends on nothing.
package sfc_pkg;

   localparam int DIV_STEPS    = 15;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [14:0] CONF_MAX   = 15'd24576;
   localparam logic [14:0] CONF_HALF  = 15'd8192;
   localparam logic [14:0] CONF_ROCK  = 15'd4915;
   localparam logic signed [17:0] CONF_ONE = 18'sd16384;

   typedef enum logic [2:0] {
      CLASS_SNOW   = 3'd0,
      CLASS_ICE    = 3'd1,
      CLASS_ROCK   = 3'd2,
      CLASS_WATER  = 3'd3,
      CLASS_VEG    = 3'd4,
      CLASS_DEBRIS = 3'd5
   } surface_class_type;

   typedef enum logic [2:0] {
      CSR_SNOW_THR   = 3'd0,
      CSR_WATER_THR  = 3'd1,
      CSR_VEG_THR    = 3'd2,
      CSR_BARE_LIMIT = 3'd3,
      CSR_DEBRIS_LIM = 3'd4,
      CSR_SWIR_PRES  = 3'd5
   } csr_index_type;

   localparam logic signed [15:0] RST_SNOW_THR   = 16'sd6554;
   localparam logic signed [15:0] RST_WATER_THR  = 16'sd4915;
   localparam logic signed [15:0] RST_VEG_THR    = 16'sd4915;
   localparam logic signed [15:0] RST_BARE_LIMIT = 16'sd1638;
   localparam logic signed [15:0] RST_DEBRIS_LIM = -16'sd1638;

   typedef struct packed {
      logic signed [15:0] snow_threshold;
      logic signed [15:0] water_threshold;
      logic signed [15:0] vegetation_threshold;
      logic signed [15:0] bare_vegetation_limit;
      logic signed [15:0] debris_ratio_limit;
      logic               swir_present;
   } cfg_type;

   // One classified pixel waiting for the swir ratio divide
   typedef struct packed {
      logic              bare;
      surface_class_type cls;
      logic [14:0]       conf;
      logic              neg;
      logic [15:0]       mag;
      logic [16:0]       den;
   } queue_entry_type;

   typedef struct packed {
      logic              bare;
      surface_class_type cls;
      logic [14:0]       conf;
      logic              neg;
      logic [16:0]       rem;
      logic [14:0]       low;
      logic [14:0]       quo;
      logic [16:0]       den;
   } div_stage_type;

   function automatic logic [14:0] sat_conf(input logic signed [17:0] c);
      logic [14:0] r;
      if (c < 18'sd0) begin
         r = 15'd0;
      end else if (c > $signed({3'b000, CONF_MAX})) begin
         r = CONF_MAX;
      end else begin
         r = c[14:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/sfc_front.sv]
// Front end: threshold tests in priority order and swir ratio operands.
// Depends on sfc_pkg.
module sfc_front
   import sfc_pkg::*;
(
   input  cfg_type                 cfg,
   input  logic signed [15:0]      snow_index,
   input  logic signed [15:0]      water_index,
   input  logic signed [15:0]      vegetation_index,
   input  logic [2:0]              index_invalid,
   input  logic [15:0]             swir_band1,
   input  logic [15:0]             swir_band2,
   output queue_entry_type         entry
);

   logic              snow_ok;
   logic              water_ok;
   logic              veg_ok;
   logic [16:0]       swir_sum;
   logic signed [16:0] veg_ext;
   logic [16:0]       veg_abs;
   logic signed [17:0] bare_conf;

   always_comb begin
      snow_ok  = !index_invalid[0];
      water_ok = !index_invalid[1];
      veg_ok   = !index_invalid[2];

      swir_sum = {1'b0, swir_band1} + {1'b0, swir_band2};
      veg_ext  = {vegetation_index[15], vegetation_index};
      veg_abs  = vegetation_index[15] ? 17'(-veg_ext) : 17'(veg_ext);
      bare_conf = CONF_ONE - $signed({1'b0, veg_abs});

      entry.bare = 1'b0;
      entry.cls  = CLASS_ROCK;
      entry.conf = CONF_ROCK;
      entry.neg  = swir_band2 > swir_band1;
      entry.mag  = entry.neg ? (swir_band2 - swir_band1) : (swir_band1 - swir_band2);
      entry.den  = swir_sum;
      if (!cfg.swir_present || swir_sum == 17'd0) begin
         entry.neg = 1'b0;
         entry.mag = 16'd0;
         entry.den = 17'd1;
      end

      if (snow_ok && snow_index > cfg.snow_threshold) begin
         entry.cls  = CLASS_SNOW;
         entry.conf = sat_conf($signed({{2{snow_index[15]}}, snow_index}));
      end else if (water_ok && water_index > cfg.water_threshold) begin
         entry.cls  = CLASS_WATER;
         entry.conf = sat_conf($signed({{2{water_index[15]}}, water_index}));
      end else if (veg_ok && vegetation_index > cfg.vegetation_threshold) begin
         entry.cls  = CLASS_VEG;
         entry.conf = sat_conf($signed({{2{vegetation_index[15]}}, vegetation_index}));
      end else if (veg_ok && vegetation_index < cfg.bare_vegetation_limit &&
                   snow_ok && snow_index < 16'sd0) begin
         entry.bare = 1'b1;
         entry.cls  = CLASS_ROCK;
         entry.conf = sat_conf(bare_conf);
      end
   end

endmodule

[rtl/core/sfc_queue.sv]
// Short queue decoupling the classifying front end from the divide pipeline.
// Depends on sfc_pkg.
module sfc_queue
   import sfc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type entry_in,
   input  logic            pop,
   output queue_entry_type entry_out,
   output logic            empty,
   output logic            full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   queue_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = count_ff == '0;
   assign full      = count_ff == CNT_FULL;
   assign entry_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && full |-> pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

[rtl/core/sfc_back.sv]
// Back end: bit-per-stage swir ratio divide, debris test and result register.
// Depends on sfc_pkg.
module sfc_back
   import sfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic signed [15:0] debris_ratio_limit,
   input  queue_entry_type    entry,
   input  logic               entry_present,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_surface_class,
   output logic [14:0]        rsp_confidence
);

   div_stage_type      stage_ff [DIV_STEPS];
   div_stage_type      stage_in [DIV_STEPS];
   div_stage_type      stage_src [DIV_STEPS];
   logic [DIV_STEPS-1:0] valid_ff;
   logic               advance;
   logic               rsp_valid_ff;
   surface_class_type  class_ff, class_in;
   logic [14:0]        conf_ff, conf_in;
   div_stage_type      last;
   logic signed [16:0] ratio;
   logic               debris;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && entry_present;

   always_comb begin
      stage_src[0].bare = entry.bare;
      stage_src[0].cls  = entry.cls;
      stage_src[0].conf = entry.conf;
      stage_src[0].neg  = entry.neg;
      stage_src[0].rem  = {2'b00, entry.mag[15:1]};
      stage_src[0].low  = {entry.mag[0], 14'd0};
      stage_src[0].quo  = 15'd0;
      stage_src[0].den  = entry.den;
   end

   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_src
      assign stage_src[k] = stage_ff[k-1];
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [17:0] shifted;
      always_comb begin
         shifted     = {stage_src[k].rem, stage_src[k].low[14]};
         stage_in[k] = stage_src[k];
         stage_in[k].low = {stage_src[k].low[13:0], 1'b0};
         if (shifted >= {1'b0, stage_src[k].den}) begin
            stage_in[k].rem = 17'(shifted - {1'b0, stage_src[k].den});
            stage_in[k].quo = {stage_src[k].quo[13:0], 1'b1};
         end else begin
            stage_in[k].rem = shifted[16:0];
            stage_in[k].quo = {stage_src[k].quo[13:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= (k == 0) ? entry_present : valid_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   always_comb begin
      last   = stage_ff[DIV_STEPS-1];
      ratio  = last.neg ? -$signed({2'b00, last.quo}) : $signed({2'b00, last.quo});
      debris = last.bare && (ratio < $signed({debris_ratio_limit[15], debris_ratio_limit}));
      class_in = debris ? CLASS_DEBRIS : last.cls;
      conf_in  = debris ? (CONF_HALF + last.quo) : last.conf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         class_ff <= class_in;
         conf_ff  <= conf_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_surface_class = class_ff;
   assign rsp_confidence    = conf_ff;

   a_no_ice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> class_ff != CLASS_ICE)
      else $error("ice class produced");

   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> conf_ff <= CONF_MAX)
      else $error("confidence above saturation limit");

   a_debris_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && class_ff == CLASS_DEBRIS |-> conf_ff >= CONF_HALF)
      else $error("debris confidence below one half");

   a_quotient_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STEPS-1] |-> last.quo <= 15'd16384)
      else $error("swir ratio magnitude above one");

endmodule

[rtl/core/surface_class_by_spectral_indices.sv]
// Surface classifier top level: threshold registers, front end, queue, divide back end.
// Depends on sfc_pkg, sfc_front, sfc_queue and sfc_back.
//
// One result per accepted pixel, in order. The block sustains one pixel per clock:
// while rsp_stall is low: the front end classifies a pixel in the cycle it is
// accepted and writes it to a short queue; the back end pulls one entry per cycle
// into a fifteen-stage divider (one quotient bit per stage) for the swir ratio,
// then a result register. Each pixel passes through the queue, the divider
// stages and the result register before rsp_valid rises. When the result side
// stalls the whole back end holds; the queue absorbs pixels until it is full,
// then req_stall rises. Thresholds are written through the csr port,
// which is always ready; writes are expected only while no pixel is in flight.
module surface_class_by_spectral_indices
   import sfc_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_snow_index,
   input  logic signed [15:0] req_water_index,
   input  logic signed [15:0] req_vegetation_index,
   input  logic [2:0]         req_index_invalid,
   input  logic [15:0]        req_swir_band1,
   input  logic [15:0]        req_swir_band2,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_surface_class,
   output logic [14:0]        rsp_confidence
);

   cfg_type         cfg_ff, cfg_in;
   queue_entry_type front_entry;
   queue_entry_type head_entry;
   logic            queue_empty;
   logic            queue_full;
   logic            push;
   logic            pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SNOW_THR:   cfg_in.snow_threshold        = csr_wdata;
            CSR_WATER_THR:  cfg_in.water_threshold       = csr_wdata;
            CSR_VEG_THR:    cfg_in.vegetation_threshold  = csr_wdata;
            CSR_BARE_LIMIT: cfg_in.bare_vegetation_limit = csr_wdata;
            CSR_DEBRIS_LIM: cfg_in.debris_ratio_limit    = csr_wdata;
            CSR_SWIR_PRES:  cfg_in.swir_present          = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.snow_threshold        <= RST_SNOW_THR;
         cfg_ff.water_threshold       <= RST_WATER_THR;
         cfg_ff.vegetation_threshold  <= RST_VEG_THR;
         cfg_ff.bare_vegetation_limit <= RST_BARE_LIMIT;
         cfg_ff.debris_ratio_limit    <= RST_DEBRIS_LIM;
         cfg_ff.swir_present          <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !req_stall;

   sfc_front u_front (
      .cfg              (cfg_ff),
      .snow_index       (req_snow_index),
      .water_index      (req_water_index),
      .vegetation_index (req_vegetation_index),
      .index_invalid    (req_index_invalid),
      .swir_band1       (req_swir_band1),
      .swir_band2       (req_swir_band2),
      .entry            (front_entry)
   );

   sfc_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (front_entry),
      .pop       (pop),
      .entry_out (head_entry),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   sfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .debris_ratio_limit (cfg_ff.debris_ratio_limit),
      .entry              (head_entry),
      .entry_present      (!queue_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_surface_class  (rsp_surface_class),
      .rsp_confidence     (rsp_confidence)
   );

endmodule
